### sv/max_heap_priority_queue_top_assert.svh
// Assertion macros used by the queue's control module.
`ifndef MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH
`define MAX_HEAP_PRIORITY_QUEUE_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MHPQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("max heap queue assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define MHPQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("max heap queue assertion failed");

`endif

### sv/mhpq_pkg.sv
`default_nettype none
package mhpq_pkg;

   localparam int Capacity = 64;
   localparam int DataW    = 32;
   localparam int AddrW    = $clog2(Capacity);
   localparam int CntW     = $clog2(Capacity + 1);
   localparam int ChildW   = AddrW + 2;
   localparam int CountOutW = 7;

   typedef logic [DataW-1:0]     data_type;
   typedef logic [AddrW-1:0]     addr_type;
   typedef logic [CntW-1:0]      cnt_type;
   typedef logic [ChildW-1:0]    child_type;
   typedef logic [CountOutW-1:0] entry_count_type;

   localparam logic ActInsert = 1'b0;
   localparam logic ActDelete = 1'b1;

   typedef enum logic [1:0] {
      STAT_OK,
      STAT_FULL,
      STAT_EMPTY,
      STAT_NOT_FOUND
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_CHK,
      ST_UP_CMP,
      ST_SCAN,
      ST_LAST_RD,
      ST_LAST_CMP,
      ST_DN_CHK,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_PICK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic     rd_en;
      addr_type rd_addr;
      logic     wr_en;
      addr_type wr_addr;
      data_type wr_data;
   } mem_req_type;

   typedef struct packed {
      logic gt;
      logic eq;
   } cmp_res_type;

endpackage
`default_nettype wire

### sv/mhpq_ram.sv
`default_nettype none
module mhpq_ram #(
   parameter int Width = 32,
   parameter int Depth = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);

   logic [Width-1:0] mem_ff [Depth];
   logic [Width-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### sv/mhpq_cmp.sv
`default_nettype none
module mhpq_cmp (
   input  wire mhpq_pkg::data_type    op_a,
   input  wire mhpq_pkg::data_type    op_b,
   output mhpq_pkg::cmp_res_type      res
);

   // Signed order on two's complement values.
   always_comb begin
      res.gt = $signed(op_a) > $signed(op_b);
      res.eq = op_a == op_b;
   end

endmodule
`default_nettype wire

### sv/mhpq_ctrl.sv
`default_nettype none
module mhpq_ctrl (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_valid,
   output logic                            req_ready,
   input  wire logic                       req_action,
   input  wire mhpq_pkg::data_type         req_value,
   output logic                            rsp_valid,
   input  wire logic                       rsp_ready,
   output logic [1:0]                      rsp_status,
   output mhpq_pkg::data_type              rsp_top_value,
   output mhpq_pkg::entry_count_type       rsp_entry_count,
   output mhpq_pkg::mem_req_type           mem_req,
   input  wire mhpq_pkg::data_type         mem_rd_data
);

   `include "max_heap_priority_queue_top_assert.svh"

   mhpq_pkg::state_type       state_ff, state_in;
   mhpq_pkg::data_type        cur_ff, cur_in;
   mhpq_pkg::addr_type        pos_ff, pos_in;
   mhpq_pkg::cnt_type         count_ff, count_in;
   mhpq_pkg::cnt_type         scan_ff, scan_in;
   logic                      pend_ff, pend_in;
   mhpq_pkg::addr_type        pend_addr_ff, pend_addr_in;
   mhpq_pkg::data_type        pick_val_ff, pick_val_in;
   mhpq_pkg::addr_type        pick_pos_ff, pick_pos_in;
   logic                      first_ff, first_in;
   mhpq_pkg::status_type      status_ff, status_in;
   mhpq_pkg::data_type        top_ff, top_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   mhpq_pkg::status_type      rsp_status_ff, rsp_status_in;
   mhpq_pkg::data_type        rsp_top_ff, rsp_top_in;
   mhpq_pkg::entry_count_type rsp_count_ff, rsp_count_in;

   mhpq_pkg::addr_type        parent;
   mhpq_pkg::child_type       child_l;
   mhpq_pkg::child_type       child_r;
   mhpq_pkg::child_type       count_ext;
   mhpq_pkg::data_type        cmp_a;
   mhpq_pkg::data_type        cmp_b;
   mhpq_pkg::cmp_res_type     cmp_res;
   logic                      rsp_load;

   mhpq_cmp u_cmp (
      .op_a (cmp_a),
      .op_b (cmp_b),
      .res  (cmp_res)
   );

   assign parent    = (pos_ff - mhpq_pkg::addr_type'(1)) >> 1;
   assign child_l   = {1'b0, pos_ff, 1'b1};
   assign child_r   = child_l + mhpq_pkg::child_type'(1);
   assign count_ext = mhpq_pkg::child_type'(count_ff);

   always_comb begin
      case (state_ff)
         mhpq_pkg::ST_UP_CMP: begin
            cmp_a = cur_ff;
            cmp_b = mem_rd_data;
         end
         mhpq_pkg::ST_DN_RIGHT: begin
            cmp_a = mem_rd_data;
            cmp_b = pick_val_ff;
         end
         mhpq_pkg::ST_DN_PICK: begin
            cmp_a = pick_val_ff;
            cmp_b = cur_ff;
         end
         default: begin
            cmp_a = mem_rd_data;
            cmp_b = cur_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mhpq_pkg::ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff        <= cur_in;
      pos_ff        <= pos_in;
      scan_ff       <= scan_in;
      pend_ff       <= pend_in;
      pend_addr_ff  <= pend_addr_in;
      pick_val_ff   <= pick_val_in;
      pick_pos_ff   <= pick_pos_in;
      first_ff      <= first_in;
      status_ff     <= status_in;
      top_ff        <= top_in;
      rsp_status_ff <= rsp_status_in;
      rsp_top_ff    <= rsp_top_in;
      rsp_count_ff  <= rsp_count_in;
   end

   always_comb begin
      state_in     = state_ff;
      cur_in       = cur_ff;
      pos_in       = pos_ff;
      count_in     = count_ff;
      scan_in      = scan_ff;
      pend_in      = 1'b0;
      pend_addr_in = pend_addr_ff;
      pick_val_in  = pick_val_ff;
      pick_pos_in  = pick_pos_ff;
      first_in     = first_ff;
      status_in    = status_ff;
      req_ready    = 1'b0;
      rsp_load     = 1'b0;
      mem_req      = '0;

      case (state_ff)
         mhpq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cur_in    = req_value;
               status_in = mhpq_pkg::STAT_OK;
               first_in  = 1'b0;
               if (req_action == mhpq_pkg::ActInsert) begin
                  if (count_ff == mhpq_pkg::cnt_type'(mhpq_pkg::Capacity)) begin
                     status_in = mhpq_pkg::STAT_FULL;
                     state_in  = mhpq_pkg::ST_DONE;
                  end else begin
                     pos_in   = count_ff[mhpq_pkg::AddrW-1:0];
                     count_in = count_ff + mhpq_pkg::cnt_type'(1);
                     state_in = mhpq_pkg::ST_UP_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     status_in = mhpq_pkg::STAT_EMPTY;
                     state_in  = mhpq_pkg::ST_DONE;
                  end else begin
                     scan_in  = '0;
                     state_in = mhpq_pkg::ST_SCAN;
                  end
               end
            end
         end
         mhpq_pkg::ST_UP_CHK: begin
            if (pos_ff == '0) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = cur_ff;
               state_in        = mhpq_pkg::ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = parent;
               state_in        = mhpq_pkg::ST_UP_CMP;
            end
         end
         mhpq_pkg::ST_UP_CMP: begin
            first_in = 1'b0;
            if (cmp_res.gt) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = mem_rd_data;
               pos_in          = parent;
               state_in        = mhpq_pkg::ST_UP_CHK;
            end else if (first_ff) begin
               state_in = mhpq_pkg::ST_DN_CHK;
            end else begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = cur_ff;
               state_in        = mhpq_pkg::ST_DONE;
            end
         end
         mhpq_pkg::ST_SCAN: begin
            mem_req.rd_addr = scan_ff[mhpq_pkg::AddrW-1:0];
            if (pend_ff && cmp_res.eq) begin
               pos_in   = pend_addr_ff;
               count_in = count_ff - mhpq_pkg::cnt_type'(1);
               state_in = mhpq_pkg::ST_LAST_RD;
            end else if (scan_ff < count_ff) begin
               mem_req.rd_en = 1'b1;
               pend_in       = 1'b1;
               pend_addr_in  = scan_ff[mhpq_pkg::AddrW-1:0];
               scan_in       = scan_ff + mhpq_pkg::cnt_type'(1);
            end else if (!pend_ff) begin
               status_in = mhpq_pkg::STAT_NOT_FOUND;
               state_in  = mhpq_pkg::ST_DONE;
            end
         end
         mhpq_pkg::ST_LAST_RD: begin
            if (mhpq_pkg::cnt_type'(pos_ff) == count_ff) begin
               state_in = mhpq_pkg::ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = count_ff[mhpq_pkg::AddrW-1:0];
               state_in        = mhpq_pkg::ST_LAST_CMP;
            end
         end
         mhpq_pkg::ST_LAST_CMP: begin
            cur_in = mem_rd_data;
            if (pos_ff == '0) begin
               state_in = mhpq_pkg::ST_DN_CHK;
            end else begin
               first_in = 1'b1;
               state_in = mhpq_pkg::ST_UP_CHK;
            end
         end
         mhpq_pkg::ST_DN_CHK: begin
            if (child_l >= count_ext) begin
               mem_req.wr_en   = 1'b1;
               mem_req.wr_addr = pos_ff;
               mem_req.wr_data = cur_ff;
               state_in        = mhpq_pkg::ST_DONE;
            end else begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = child_l[mhpq_pkg::AddrW-1:0];
               state_in        = mhpq_pkg::ST_DN_LEFT;
            end
         end
         mhpq_pkg::ST_DN_LEFT: begin
            pick_val_in = mem_rd_data;
            pick_pos_in = child_l[mhpq_pkg::AddrW-1:0];
            if (child_r < count_ext) begin
               mem_req.rd_en   = 1'b1;
               mem_req.rd_addr = child_r[mhpq_pkg::AddrW-1:0];
               state_in        = mhpq_pkg::ST_DN_RIGHT;
            end else begin
               state_in = mhpq_pkg::ST_DN_PICK;
            end
         end
         mhpq_pkg::ST_DN_RIGHT: begin
            if (cmp_res.gt) begin
               pick_val_in = mem_rd_data;
               pick_pos_in = child_r[mhpq_pkg::AddrW-1:0];
            end
            state_in = mhpq_pkg::ST_DN_PICK;
         end
         mhpq_pkg::ST_DN_PICK: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pos_ff;
            if (cmp_res.gt) begin
               mem_req.wr_data = pick_val_ff;
               pos_in          = pick_pos_ff;
               state_in        = mhpq_pkg::ST_DN_CHK;
            end else begin
               mem_req.wr_data = cur_ff;
               state_in        = mhpq_pkg::ST_DONE;
            end
         end
         mhpq_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = mhpq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = mhpq_pkg::ST_IDLE;
         end
      endcase
   end

   // The top entry is mirrored in a register so the result never reads the memory.
   always_comb begin
      top_in = top_ff;
      if (mem_req.wr_en && mem_req.wr_addr == '0) begin
         top_in = mem_req.wr_data;
      end
   end

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_top_in    = rsp_top_ff;
      rsp_count_in  = rsp_count_ff;
      if (rsp_load) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = status_ff;
         rsp_top_in    = (count_ff != '0) ? top_ff : '0;
         rsp_count_in  = mhpq_pkg::entry_count_type'(count_ff);
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_top_value   = rsp_top_ff;
   assign rsp_entry_count = rsp_count_ff;

   `MHPQ_ASSERT_NOW(a_count_range, clock, reset, 1'b1,
      count_ff <= mhpq_pkg::cnt_type'(mhpq_pkg::Capacity))
   `MHPQ_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready,
      state_ff != mhpq_pkg::ST_IDLE)
   `MHPQ_ASSERT_NOW(a_no_rw_collision, clock, reset, mem_req.rd_en && mem_req.wr_en,
      mem_req.rd_addr != mem_req.wr_addr)
   `MHPQ_ASSERT_NOW(a_full_status, clock, reset,
      rsp_load && status_ff == mhpq_pkg::STAT_FULL,
      count_ff == mhpq_pkg::cnt_type'(mhpq_pkg::Capacity))
   `MHPQ_ASSERT_NEXT(a_rsp_loaded, clock, reset, rsp_load, rsp_valid_ff)

endmodule
`default_nettype wire

### sv/max_heap_priority_queue_top.sv
// Bounded max-heap priority queue of signed 32-bit values (64 entries).
// Request channel (req_valid/req_ready): req_action selects insert (0) or
// delete of one stored occurrence (1) of req_value. Response channel
// (rsp_valid/rsp_ready): one response per request with rsp_status (ok, full,
// empty, not found), rsp_top_value (largest value, zero when empty) and
// rsp_entry_count. The heap lives in a single-port-read RAM and one shared
// compare unit works through it under a small sequencer, one request at a
// time. An insert climbs the new value from the end of the heap upward.
// A delete scans the heap one entry per cycle until it finds the value or
// reaches the end, then restores heap order by moving the last entry into
// its slot and sifting it upward or downward. Each RAM read is registered.
// Reset empties the queue at once; no clearing pass is needed. A finished
// response sits in an output register, so a new request is accepted while
// it waits; if the receiver stalls, the next response holds in the
// sequencer until the slot frees.
`default_nettype none
module max_heap_priority_queue_top (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_action,
   input  wire logic signed [31:0]   req_value,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_status,
   output logic signed [31:0]        rsp_top_value,
   output logic [6:0]                rsp_entry_count
);

   mhpq_pkg::mem_req_type mem_req;
   mhpq_pkg::data_type    mem_rd_data;
   mhpq_pkg::data_type    top_value;

   mhpq_ctrl u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_top_value   (top_value),
      .rsp_entry_count (rsp_entry_count),
      .mem_req         (mem_req),
      .mem_rd_data     (mem_rd_data)
   );

   mhpq_ram #(
      .Width (mhpq_pkg::DataW),
      .Depth (mhpq_pkg::Capacity)
   ) u_heap_ram (
      .clock   (clock),
      .wr_en   (mem_req.wr_en),
      .wr_addr (mem_req.wr_addr),
      .wr_data (mem_req.wr_data),
      .rd_en   (mem_req.rd_en),
      .rd_addr (mem_req.rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_top_value = $signed(top_value);

endmodule
`default_nettype wire

### dv/max_heap_priority_queue_checker.sv
module max_heap_priority_queue_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic               req_action,
   input  logic signed [31:0] req_value,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [1:0]         rsp_status,
   input  logic signed [31:0] rsp_top_value,
   input  logic [6:0]         rsp_entry_count,
   output int                 mismatch_count,
   output int                 pending_count
);

   typedef struct packed {
      mhpq_pkg::status_type status;
      logic signed [31:0]   top_value;
      logic [6:0]           entry_count;
   } heap_outcome_type;

   logic signed [31:0] heap_model [mhpq_pkg::Capacity];
   int                 heap_count;
   int                 error_total;
   heap_outcome_type   awaited_outcomes [$];

   function automatic void raise_entry(input int start);
      int                 pos;
      int                 parent;
      logic signed [31:0] held;
      pos = start;
      parent = (pos - 1) / 2;
      while (pos > 0 && heap_model[pos] > heap_model[parent]) begin
         held = heap_model[pos];
         heap_model[pos] = heap_model[parent];
         heap_model[parent] = held;
         pos = parent;
         parent = (pos - 1) / 2;
      end
   endfunction

   function automatic heap_outcome_type apply_heap_request(input logic act,
                                                           input logic signed [31:0] val);
      heap_outcome_type   outcome;
      int                 hit;
      int                 pos;
      int                 pick;
      bit                 settled;
      logic signed [31:0] held;
      outcome.status = mhpq_pkg::STAT_OK;
      if (act == mhpq_pkg::ActInsert) begin
         if (heap_count >= mhpq_pkg::Capacity) begin
            outcome.status = mhpq_pkg::STAT_FULL;
         end else begin
            heap_model[heap_count] = val;
            heap_count++;
            raise_entry(heap_count - 1);
         end
      end else if (heap_count == 0) begin
         outcome.status = mhpq_pkg::STAT_EMPTY;
      end else begin
         hit = -1;
         for (int i = 0; i < heap_count; i++) begin
            if (hit < 0 && heap_model[i] == val) hit = i;
         end
         if (hit < 0) begin
            outcome.status = mhpq_pkg::STAT_NOT_FOUND;
         end else begin
            heap_count--;
            heap_model[hit] = heap_model[heap_count];
            if (hit < heap_count) begin
               if (hit > 0 && heap_model[hit] > heap_model[(hit - 1) / 2]) begin
                  raise_entry(hit);
               end else begin
                  // The moved entry sinks toward its larger child; ties favor the left.
                  pos = hit;
                  settled = 1'b0;
                  while (!settled && 2 * pos + 1 < heap_count) begin
                     pick = 2 * pos + 1;
                     if (pick + 1 < heap_count && heap_model[pick + 1] > heap_model[pick])
                        pick = pick + 1;
                     if (heap_model[pick] > heap_model[pos]) begin
                        held = heap_model[pos];
                        heap_model[pos] = heap_model[pick];
                        heap_model[pick] = held;
                        pos = pick;
                     end else begin
                        settled = 1'b1;
                     end
                  end
               end
            end
         end
      end
      outcome.top_value = (heap_count > 0) ? heap_model[0] : 32'sd0;
      outcome.entry_count = 7'(heap_count);
      return outcome;
   endfunction

   always @(posedge clock) begin : watch_channels
      heap_outcome_type oldest;
      if (reset) begin
         heap_count = 0;
         awaited_outcomes.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (awaited_outcomes.size() == 0) begin
               $error("response with no request pending: status %0d top %0d count %0d",
                      rsp_status, rsp_top_value, rsp_entry_count);
               error_total++;
            end else begin
               oldest = awaited_outcomes.pop_front();
               if (rsp_status !== oldest.status) begin
                  $error("rsp_status: expected %0d, got %0d", oldest.status, rsp_status);
                  error_total++;
               end
               if (rsp_top_value !== oldest.top_value) begin
                  $error("rsp_top_value: expected %0d, got %0d",
                         oldest.top_value, rsp_top_value);
                  error_total++;
               end
               if (rsp_entry_count !== oldest.entry_count) begin
                  $error("rsp_entry_count: expected %0d, got %0d",
                         oldest.entry_count, rsp_entry_count);
                  error_total++;
               end
            end
         end
         if (req_valid && req_ready)
            awaited_outcomes.push_back(apply_heap_request(req_action, req_value));
      end
      mismatch_count <= error_total;
      pending_count <= awaited_outcomes.size();
   end

endmodule

### dv/max_heap_priority_queue_top_tb.sv
module max_heap_priority_queue_top_tb;

   localparam int RandomItems = 1630;
   localparam int PhaseLen    = 80;
   localparam int StallLimit  = 2000;
   localparam int DrainCycles = 100;

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_action;
   logic signed [31:0] req_value;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [1:0]         rsp_status;
   logic signed [31:0] rsp_top_value;
   logic [6:0]         rsp_entry_count;
   int                 mismatch_count;
   int                 pending_count;

   bit                 quiet_phase;
   int unsigned        ready_hold;
   int                 idle_cycles;
   int                 insert_mix [6] = '{90, 35, 100, 10, 60, 50};
   logic signed [31:0] stored_vals [$];

   max_heap_priority_queue_top u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_top_value   (rsp_top_value),
      .rsp_entry_count (rsp_entry_count)
   );

   max_heap_priority_queue_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_action      (req_action),
      .req_value       (req_value),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_top_value   (rsp_top_value),
      .rsp_entry_count (rsp_entry_count),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count)
   );

   initial clock = 1'b0;
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   function automatic logic signed [31:0] draw_value();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return $urandom;
      if (pick < 75) return int'($urandom_range(0, 8)) - 4;
      if (pick < 90) begin
         case ($urandom_range(0, 5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return 32'sh7ffffffe;
            3: return 32'sh80000001;
            4: return -32'sd1;
            default: return 32'sd0;
         endcase
      end
      return int'($urandom_range(0, 2000)) - 1000;
   endfunction

   task automatic send_request(input logic act, input logic signed [31:0] val);
      int unsigned gap;
      int          slot;
      gap = quiet_phase ? 0 : $urandom_range(0, 13);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_action <= act;
      req_value <= val;
      do @(posedge clock); while (!req_ready);
      if (act == mhpq_pkg::ActInsert) begin
         if (stored_vals.size() < mhpq_pkg::Capacity) stored_vals.push_back(val);
      end else begin
         slot = -1;
         foreach (stored_vals[i]) begin
            if (slot < 0 && stored_vals[i] == val) slot = i;
         end
         if (slot >= 0) stored_vals.delete(slot);
      end
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         ready_hold = 0;
      end else if (rsp_valid && rsp_ready) begin
         ready_hold = quiet_phase ? 0 : $urandom_range(0, 13);
         rsp_ready <= (ready_hold == 0);
      end else if (!rsp_ready) begin
         if (ready_hold == 0) rsp_ready <= 1'b1;
         else ready_hold--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= StallLimit) begin
         $display("Mismatches found");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      int insert_pct;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_action <= mhpq_pkg::ActInsert;
      req_value <= '0;
      quiet_phase = 1'b0;
      insert_pct = 50;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      send_request(mhpq_pkg::ActDelete, 32'sd9);
      send_request(mhpq_pkg::ActInsert, 32'sd0);
      send_request(mhpq_pkg::ActInsert, 32'sh7fffffff);
      send_request(mhpq_pkg::ActInsert, 32'sh80000000);
      send_request(mhpq_pkg::ActInsert, -32'sd1);
      send_request(mhpq_pkg::ActInsert, 32'sd5);
      send_request(mhpq_pkg::ActInsert, 32'sd5);
      send_request(mhpq_pkg::ActInsert, 32'sd3);
      send_request(mhpq_pkg::ActInsert, 32'sd3);
      send_request(mhpq_pkg::ActDelete, 32'sd12345);
      send_request(mhpq_pkg::ActDelete, 32'sh80000000);
      send_request(mhpq_pkg::ActDelete, 32'sh7fffffff);
      send_request(mhpq_pkg::ActDelete, 32'sd5);
      send_request(mhpq_pkg::ActInsert, 32'sd4);
      send_request(mhpq_pkg::ActDelete, 32'sd0);
      send_request(mhpq_pkg::ActDelete, 32'sd5);
      send_request(mhpq_pkg::ActDelete, 32'sd5);
      send_request(mhpq_pkg::ActDelete, -32'sd1);
      send_request(mhpq_pkg::ActDelete, 32'sd3);
      send_request(mhpq_pkg::ActDelete, 32'sd4);
      send_request(mhpq_pkg::ActDelete, 32'sd3);
      send_request(mhpq_pkg::ActDelete, 32'sd3);

      // Hold off new requests until every outstanding response is back.
      wait_for_responses();

      for (int n = 0; n < RandomItems; n++) begin
         if (n % PhaseLen == 0) begin
            insert_pct = insert_mix[(n / PhaseLen) % 6];
            quiet_phase = ((n / PhaseLen) % 4 == 3);
         end
         if ($urandom_range(0, 99) < insert_pct)
            send_request(mhpq_pkg::ActInsert, draw_value());
         else if (stored_vals.size() > 0 && $urandom_range(0, 99) < 70)
            send_request(mhpq_pkg::ActDelete,
                         stored_vals[$urandom_range(0, stored_vals.size() - 1)]);
         else
            send_request(mhpq_pkg::ActDelete, draw_value());
      end

      wait_for_responses();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule
